FILE: rtl/core/hhlru_pkg.sv
// Shared types, codes and helpers for the handle heap manager.
// Used by hhlru_ctrl, hhlru_dpath and handle_heap_lru_discard; no dependencies.
package hhlru_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_NEW     = 3'd0,
        CMD_RESIZE  = 3'd1,
        CMD_DISCARD = 3'd2,
        CMD_LOCK    = 3'd3,
        CMD_UNLOCK  = 3'd4,
        CMD_TOUCH   = 3'd5,
        CMD_RELEASE = 3'd6,
        CMD_FIXED   = 3'd7
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFREE  = 3'd1,
        ST_NOROOM  = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_NOFIXED = 3'd4,
        ST_BAD     = 3'd5
    } stat_t;

    // Entry flag bits
    localparam logic [2:0] FL_USED = 3'b001;
    localparam logic [2:0] FL_DISC = 3'b010;
    localparam logic [2:0] FL_LOCK = 3'b100;

    localparam logic [23:0] POOL_RESET = 24'd5242880;
    localparam int          ALIGN      = 8;

    localparam logic signed [27:0] BUD_MAX = 28'sd33554431;
    localparam logic signed [27:0] BUD_MIN = -28'sd33554432;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECIDE, S_EV_CHK, S_SCAN_START, S_SCAN_RD,
        S_SCAN_CHK, S_DROP, S_RSZ_WR, S_UNL1, S_UNL2, S_APP1, S_APP2, S_FINISH
    } state_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_FETCH, OP_DECIDE, OP_SCAN_START, OP_SCAN_RD,
        OP_SCAN_CHK, OP_DROP, OP_NOROOM, OP_RSZ_WR, OP_UNL1, OP_UNL2, OP_APP1,
        OP_APP2, OP_FINISH
    } op_t;

    // Where a command goes after its entry has been examined
    typedef enum logic [1:0] {
        PATH_DONE, PATH_EVICT, PATH_UNLINK, PATH_APPEND
    } path_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        path_t path;
        logic  is_resize;
        logic  need_room;
        logic  scan_more;
        logic  pick_nil;
        logic  clear_last;
    } sts_t;

    // Add a signed delta to the budget and clamp to the 26-bit range
    function automatic logic signed [25:0] sat_add(input logic signed [25:0] b,
                                                   input logic signed [26:0] d);
        logic signed [27:0] s;
        s = 28'(b) + 28'(d);
        if (s > BUD_MAX) begin
            return 26'(BUD_MAX);
        end
        else if (s < BUD_MIN) begin
            return 26'(BUD_MIN);
        end
        return 26'(s);
    endfunction

endpackage

FILE: rtl/core/hhlru_ctrl.sv
// Sequencing state machine of the handle heap manager.
// Depends on hhlru_pkg; drives hhlru_dpath through ctl_t and reads sts_t.
module hhlru_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hhlru_pkg::sts_t sts,
    output hhlru_pkg::ctl_t ctl,
    output logic            busy
);

    hhlru_pkg::state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhlru_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue one datapath operation per cycle
    always_comb
    begin
        state_next = state_reg;
        ctl.op     = hhlru_pkg::OP_NONE;
        unique case (state_reg)
            hhlru_pkg::S_CLEAR:
            begin
                ctl.op = hhlru_pkg::OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = hhlru_pkg::S_IDLE;
                end
            end
            hhlru_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = hhlru_pkg::OP_LOAD;
                    state_next = hhlru_pkg::S_FETCH;
                end
            end
            hhlru_pkg::S_FETCH:
            begin
                ctl.op     = hhlru_pkg::OP_FETCH;
                state_next = hhlru_pkg::S_DECIDE;
            end
            hhlru_pkg::S_DECIDE:
            begin
                ctl.op = hhlru_pkg::OP_DECIDE;
                unique case (sts.path)
                    hhlru_pkg::PATH_DONE:   state_next = hhlru_pkg::S_FINISH;
                    hhlru_pkg::PATH_EVICT:  state_next = hhlru_pkg::S_EV_CHK;
                    hhlru_pkg::PATH_UNLINK: state_next = hhlru_pkg::S_UNL1;
                    hhlru_pkg::PATH_APPEND: state_next = hhlru_pkg::S_APP2;
                endcase
            end
            hhlru_pkg::S_EV_CHK:
            begin
                state_next = sts.need_room ? hhlru_pkg::S_SCAN_START : hhlru_pkg::S_RSZ_WR;
            end
            hhlru_pkg::S_SCAN_START:
            begin
                ctl.op     = hhlru_pkg::OP_SCAN_START;
                state_next = hhlru_pkg::S_SCAN_RD;
            end
            hhlru_pkg::S_SCAN_RD:
            begin
                priority if (sts.scan_more)
                begin
                    ctl.op     = hhlru_pkg::OP_SCAN_RD;
                    state_next = hhlru_pkg::S_SCAN_CHK;
                end
                else if (sts.pick_nil)
                begin
                    ctl.op     = hhlru_pkg::OP_NOROOM;
                    state_next = hhlru_pkg::S_FINISH;
                end
                else
                begin
                    state_next = hhlru_pkg::S_DROP;
                end
            end
            hhlru_pkg::S_SCAN_CHK:
            begin
                ctl.op     = hhlru_pkg::OP_SCAN_CHK;
                state_next = hhlru_pkg::S_SCAN_RD;
            end
            hhlru_pkg::S_DROP:
            begin
                ctl.op     = hhlru_pkg::OP_DROP;
                state_next = hhlru_pkg::S_EV_CHK;
            end
            hhlru_pkg::S_RSZ_WR:
            begin
                ctl.op     = hhlru_pkg::OP_RSZ_WR;
                state_next = hhlru_pkg::S_UNL1;
            end
            hhlru_pkg::S_UNL1:
            begin
                ctl.op     = hhlru_pkg::OP_UNL1;
                state_next = hhlru_pkg::S_UNL2;
            end
            hhlru_pkg::S_UNL2:
            begin
                ctl.op     = hhlru_pkg::OP_UNL2;
                state_next = sts.is_resize ? hhlru_pkg::S_APP1 : hhlru_pkg::S_FINISH;
            end
            hhlru_pkg::S_APP1:
            begin
                ctl.op     = hhlru_pkg::OP_APP1;
                state_next = hhlru_pkg::S_APP2;
            end
            hhlru_pkg::S_APP2:
            begin
                ctl.op     = hhlru_pkg::OP_APP2;
                state_next = hhlru_pkg::S_FINISH;
            end
            hhlru_pkg::S_FINISH:
            begin
                ctl.op     = hhlru_pkg::OP_FINISH;
                state_next = hhlru_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hhlru_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != hhlru_pkg::S_IDLE);

endmodule

FILE: rtl/core/hhlru_dpath.sv
// Datapath of the handle heap manager: entry memories, age list, free stack, budget.
// Depends on hhlru_pkg; driven by hhlru_ctrl through ctl_t.
module hhlru_dpath #(
    parameter int NODES       = 256,
    parameter int FIXED_SLOTS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hhlru_pkg::ctl_t     ctl,
    output hhlru_pkg::sts_t     sts,
    input  logic [2:0]          cmd,
    input  logic [7:0]          handle,
    input  logic [23:0]         size,
    input  logic [31:0]         now,
    input  logic                pool_size_we,
    input  logic [23:0]         pool_size_wdata,
    output logic [2:0]          status,
    output logic [7:0]          result_handle,
    output logic signed [25:0]  free_budget,
    output logic [8:0]          evicted_count,
    output logic                done
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NIL = LW'(NODES);
    localparam logic [24:0] AMASK = 25'(hhlru_pkg::ALIGN - 1);

    // Entry memories, one shared address per cycle
    logic [2:0]    flags_mem [NODES];
    logic [24:0]   bytes_mem [NODES];
    logic [31:0]   age_mem   [NODES];
    logic [LW-1:0] next_mem  [NODES];
    logic [LW-1:0] prev_mem  [NODES];
    logic [LW-1:0] flink_mem [NODES];

    logic [2:0]    rd_flags;
    logic [24:0]   rd_bytes;
    logic [31:0]   rd_age;
    logic [LW-1:0] rd_next, rd_prev, rd_flink;

    logic [IW-1:0] maddr;
    logic          we_flags, we_bytes, we_age, we_next, we_prev, we_flink;
    logic [2:0]    wd_flags;
    logic [24:0]   wd_bytes;
    logic [31:0]   wd_age;
    logic [LW-1:0] wd_next, wd_prev, wd_flink;

    // Control registers
    logic [IW-1:0]            clr_reg, clr_next;
    logic [LW-1:0]            head_reg, head_next, tail_reg, tail_next;
    logic [LW-1:0]            ftop_reg, ftop_next;
    logic signed [25:0]       budget_reg, budget_next;
    logic [FIXED_SLOTS-1:0]   fixed_reg, fixed_next;
    logic                     done_reg, done_next;

    // Per-command working registers
    hhlru_pkg::cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0]            tgt_reg, tgt_next;
    logic                     oor_reg, oor_next;
    logic [24:0]              al_reg, al_next;
    logic [23:0]              size_reg, size_next;
    logic [31:0]              now_reg, now_next;
    hhlru_pkg::stat_t         stat_reg, stat_next;
    logic [7:0]               rh_reg, rh_next;
    logic [8:0]               evict_reg, evict_next;
    logic [LW-1:0]            p_reg, p_next, n_reg, n_next;
    logic [LW-1:0]            cur_reg, cur_next, pick_reg, pick_next, guard_reg, guard_next;
    logic [31:0]              oldest_reg, oldest_next;
    logic [24:0]              pbytes_reg, pbytes_next;

    // Result registers
    hhlru_pkg::stat_t         ostat_reg, ostat_next;
    logic [7:0]               orh_reg, orh_next;
    logic signed [25:0]       obud_reg, obud_next;
    logic [8:0]               oev_reg, oev_next;

    // Decision on the fetched entry
    hhlru_pkg::stat_t dec_stat;
    hhlru_pkg::path_t dec_path;
    logic             slot_found;
    int               slot_idx;

    always_comb
    begin
        slot_found = 1'b0;
        slot_idx   = 0;
        for (int s = FIXED_SLOTS - 1; s >= 0; s--)
        begin
            if (!fixed_reg[s])
            begin
                slot_found = 1'b1;
                slot_idx   = s;
            end
        end

        dec_stat = hhlru_pkg::ST_OK;
        dec_path = hhlru_pkg::PATH_DONE;
        unique case (cmd_reg)
            hhlru_pkg::CMD_NEW:
            begin
                if (ftop_reg == NIL)
                begin
                    dec_stat = hhlru_pkg::ST_NOFREE;
                end
                else
                begin
                    dec_path = hhlru_pkg::PATH_APPEND;
                end
            end
            hhlru_pkg::CMD_RESIZE:
            begin
                priority if (al_reg == '0)
                begin
                    dec_stat = hhlru_pkg::ST_BAD;
                end
                else if (al_reg == rd_bytes)
                begin
                    dec_stat = hhlru_pkg::ST_OK;
                end
                else if (rd_flags != (hhlru_pkg::FL_USED | hhlru_pkg::FL_DISC) ||
                         rd_bytes != '0)
                begin
                    dec_stat = hhlru_pkg::ST_BAD;
                end
                else
                begin
                    dec_path = hhlru_pkg::PATH_EVICT;
                end
            end
            hhlru_pkg::CMD_DISCARD, hhlru_pkg::CMD_UNLOCK:
            begin
                if ((cmd_reg == hhlru_pkg::CMD_DISCARD) == (rd_flags[2] == 1'b1))
                begin
                    dec_stat = hhlru_pkg::ST_BAD;
                end
            end
            hhlru_pkg::CMD_LOCK:
            begin
                priority if (rd_flags[2])
                begin
                    dec_stat = hhlru_pkg::ST_BAD;
                end
                else if (rd_flags[1] || rd_bytes == '0)
                begin
                    dec_stat = hhlru_pkg::ST_ABSENT;
                end
                else
                begin
                    dec_stat = hhlru_pkg::ST_OK;
                end
            end
            hhlru_pkg::CMD_TOUCH:
            begin
                dec_stat = hhlru_pkg::ST_OK;
            end
            hhlru_pkg::CMD_RELEASE:
            begin
                if (rd_flags[2])
                begin
                    dec_stat = hhlru_pkg::ST_BAD;
                end
                else
                begin
                    dec_path = hhlru_pkg::PATH_UNLINK;
                end
            end
            hhlru_pkg::CMD_FIXED:
            begin
                if (!slot_found)
                begin
                    dec_stat = hhlru_pkg::ST_NOFIXED;
                end
            end
            default:
            begin
                dec_stat = hhlru_pkg::ST_BAD;
            end
        endcase

        // Handle commands on an absent entry change nothing
        if (cmd_reg != hhlru_pkg::CMD_NEW && cmd_reg != hhlru_pkg::CMD_FIXED &&
            (oor_reg || !rd_flags[0]))
        begin
            dec_stat = hhlru_pkg::ST_BAD;
            dec_path = hhlru_pkg::PATH_DONE;
        end
    end

    // Next-state logic for every operation
    always_comb
    begin
        clr_next    = clr_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ftop_next   = ftop_reg;
        budget_next = budget_reg;
        fixed_next  = fixed_reg;
        done_next   = 1'b0;
        cmd_next    = cmd_reg;
        tgt_next    = tgt_reg;
        oor_next    = oor_reg;
        al_next     = al_reg;
        size_next   = size_reg;
        now_next    = now_reg;
        stat_next   = stat_reg;
        rh_next     = rh_reg;
        evict_next  = evict_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        cur_next    = cur_reg;
        pick_next   = pick_reg;
        guard_next  = guard_reg;
        oldest_next = oldest_reg;
        pbytes_next = pbytes_reg;
        ostat_next  = ostat_reg;
        orh_next    = orh_reg;
        obud_next   = obud_reg;
        oev_next    = oev_reg;

        maddr    = tgt_reg;
        we_flags = 1'b0;
        we_bytes = 1'b0;
        we_age   = 1'b0;
        we_next  = 1'b0;
        we_prev  = 1'b0;
        we_flink = 1'b0;
        wd_flags = rd_flags;
        wd_bytes = rd_bytes;
        wd_age   = now_reg;
        wd_next  = NIL;
        wd_prev  = tail_reg;
        wd_flink = ftop_reg;

        unique case (ctl.op)
            hhlru_pkg::OP_CLEAR:
            begin
                maddr    = clr_reg;
                we_flags = 1'b1;
                we_bytes = 1'b1;
                we_age   = 1'b1;
                we_flink = 1'b1;
                wd_flags = '0;
                wd_bytes = '0;
                wd_age   = '0;
                wd_flink = LW'(clr_reg) + LW'(1);
                clr_next = clr_reg + IW'(1);
            end
            hhlru_pkg::OP_LOAD:
            begin
                cmd_next   = hhlru_pkg::cmd_t'(cmd);
                tgt_next   = (hhlru_pkg::cmd_t'(cmd) == hhlru_pkg::CMD_NEW) ?
                             ftop_reg[IW-1:0] : IW'(handle);
                oor_next   = (32'(handle) >= 32'(NODES));
                al_next    = (25'(size) + AMASK) & ~AMASK;
                size_next  = size;
                now_next   = now;
                stat_next  = hhlru_pkg::ST_OK;
                rh_next    = '0;
                evict_next = '0;
            end
            hhlru_pkg::OP_DECIDE:
            begin
                stat_next = dec_stat;
                p_next    = rd_prev;
                n_next    = rd_next;
                if (dec_stat == hhlru_pkg::ST_OK)
                begin
                    unique case (cmd_reg)
                        hhlru_pkg::CMD_NEW:
                        begin
                            we_flags  = 1'b1;
                            we_bytes  = 1'b1;
                            we_age    = 1'b1;
                            we_next   = 1'b1;
                            we_prev   = 1'b1;
                            wd_flags  = hhlru_pkg::FL_USED | hhlru_pkg::FL_DISC;
                            wd_bytes  = '0;
                            ftop_next = rd_flink;
                            rh_next   = 8'(tgt_reg);
                        end
                        hhlru_pkg::CMD_DISCARD:
                        begin
                            if (!rd_flags[1])
                            begin
                                we_flags    = 1'b1;
                                we_bytes    = 1'b1;
                                wd_flags    = rd_flags | hhlru_pkg::FL_DISC;
                                wd_bytes    = '0;
                                budget_next = hhlru_pkg::sat_add(budget_reg,
                                                                 $signed({2'b00, rd_bytes}));
                            end
                        end
                        hhlru_pkg::CMD_LOCK:
                        begin
                            we_flags = 1'b1;
                            wd_flags = rd_flags | hhlru_pkg::FL_LOCK;
                        end
                        hhlru_pkg::CMD_UNLOCK:
                        begin
                            we_flags = 1'b1;
                            we_age   = 1'b1;
                            wd_flags = rd_flags & ~hhlru_pkg::FL_LOCK;
                        end
                        hhlru_pkg::CMD_TOUCH:
                        begin
                            we_age = 1'b1;
                        end
                        hhlru_pkg::CMD_RELEASE:
                        begin
                            if (!rd_flags[1])
                            begin
                                budget_next = hhlru_pkg::sat_add(budget_reg,
                                                                 $signed({2'b00, rd_bytes}));
                            end
                            we_flags  = 1'b1;
                            we_bytes  = 1'b1;
                            we_flink  = 1'b1;
                            wd_flags  = '0;
                            wd_bytes  = '0;
                            ftop_next = LW'(tgt_reg);
                        end
                        hhlru_pkg::CMD_FIXED:
                        begin
                            fixed_next[slot_idx] = 1'b1;
                            rh_next     = 8'(slot_idx);
                            budget_next = hhlru_pkg::sat_add(budget_reg,
                                                             -$signed({3'b000, size_reg}));
                        end
                        default:
                        begin
                            // resize continues in the eviction steps
                        end
                    endcase
                end
            end
            hhlru_pkg::OP_SCAN_START:
            begin
                cur_next    = head_reg;
                pick_next   = NIL;
                oldest_next = now_reg;
                guard_next  = '0;
            end
            hhlru_pkg::OP_SCAN_RD:
            begin
                maddr = cur_reg[IW-1:0];
            end
            hhlru_pkg::OP_SCAN_CHK:
            begin
                // Keep the first oldest unlocked resident entry
                if (rd_flags == hhlru_pkg::FL_USED && rd_age < oldest_reg)
                begin
                    oldest_next = rd_age;
                    pick_next   = cur_reg;
                    pbytes_next = rd_bytes;
                end
                cur_next   = rd_next;
                guard_next = guard_reg + LW'(1);
            end
            hhlru_pkg::OP_DROP:
            begin
                maddr       = pick_reg[IW-1:0];
                we_flags    = 1'b1;
                we_bytes    = 1'b1;
                wd_flags    = hhlru_pkg::FL_USED | hhlru_pkg::FL_DISC;
                wd_bytes    = '0;
                budget_next = hhlru_pkg::sat_add(budget_reg, $signed({2'b00, pbytes_reg}));
                evict_next  = evict_reg + 9'd1;
            end
            hhlru_pkg::OP_NOROOM:
            begin
                stat_next = hhlru_pkg::ST_NOROOM;
            end
            hhlru_pkg::OP_RSZ_WR:
            begin
                we_flags    = 1'b1;
                we_bytes    = 1'b1;
                we_age      = 1'b1;
                wd_flags    = hhlru_pkg::FL_USED;
                wd_bytes    = al_reg;
                wd_age      = now_reg + 32'd1;
                budget_next = hhlru_pkg::sat_add(budget_reg, -$signed({2'b00, al_reg}));
            end
            hhlru_pkg::OP_UNL1:
            begin
                if (p_reg == NIL)
                begin
                    head_next = n_reg;
                end
                else
                begin
                    maddr   = p_reg[IW-1:0];
                    we_next = 1'b1;
                    wd_next = n_reg;
                end
            end
            hhlru_pkg::OP_UNL2:
            begin
                if (n_reg == NIL)
                begin
                    tail_next = p_reg;
                end
                else
                begin
                    maddr   = n_reg[IW-1:0];
                    we_prev = 1'b1;
                    wd_prev = p_reg;
                end
            end
            hhlru_pkg::OP_APP1:
            begin
                we_prev = 1'b1;
                we_next = 1'b1;
            end
            hhlru_pkg::OP_APP2:
            begin
                if (tail_reg == NIL)
                begin
                    head_next = LW'(tgt_reg);
                end
                else
                begin
                    maddr   = tail_reg[IW-1:0];
                    we_next = 1'b1;
                    wd_next = LW'(tgt_reg);
                end
                tail_next = LW'(tgt_reg);
            end
            hhlru_pkg::OP_FINISH:
            begin
                ostat_next = stat_reg;
                orh_next   = rh_reg;
                obud_next  = budget_reg;
                oev_next   = evict_reg;
                done_next  = 1'b1;
            end
            default:
            begin
                // idle or fetch: address the target only
            end
        endcase

        // Load the budget on a pool size write
        if (pool_size_we)
        begin
            budget_next = $signed({2'b00, pool_size_wdata});
        end
    end

    // Write and read the entry memories
    always_ff @(posedge clk)
    begin
        if (we_flags) flags_mem[maddr] <= wd_flags;
        if (we_bytes) bytes_mem[maddr] <= wd_bytes;
        if (we_age)   age_mem[maddr]   <= wd_age;
        if (we_next)  next_mem[maddr]  <= wd_next;
        if (we_prev)  prev_mem[maddr]  <= wd_prev;
        if (we_flink) flink_mem[maddr] <= wd_flink;
        rd_flags <= flags_mem[maddr];
        rd_bytes <= bytes_mem[maddr];
        rd_age   <= age_mem[maddr];
        rd_next  <= next_mem[maddr];
        rd_prev  <= prev_mem[maddr];
        rd_flink <= flink_mem[maddr];
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            ftop_reg   <= '0;
            budget_reg <= $signed({2'b00, hhlru_pkg::POOL_RESET});
            fixed_reg  <= '0;
            done_reg   <= 1'b0;
            cmd_reg    <= hhlru_pkg::CMD_NEW;
        end
        else
        begin
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            ftop_reg   <= ftop_next;
            budget_reg <= budget_next;
            fixed_reg  <= fixed_next;
            done_reg   <= done_next;
            cmd_reg    <= cmd_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        tgt_reg    <= tgt_next;
        oor_reg    <= oor_next;
        al_reg     <= al_next;
        size_reg   <= size_next;
        now_reg    <= now_next;
        stat_reg   <= stat_next;
        rh_reg     <= rh_next;
        evict_reg  <= evict_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        cur_reg    <= cur_next;
        pick_reg   <= pick_next;
        guard_reg  <= guard_next;
        oldest_reg <= oldest_next;
        pbytes_reg <= pbytes_next;
        ostat_reg  <= ostat_next;
        orh_reg    <= orh_next;
        obud_reg   <= obud_next;
        oev_reg    <= oev_next;
    end

    // Status to the controller
    assign sts.path       = dec_path;
    assign sts.is_resize  = (cmd_reg == hhlru_pkg::CMD_RESIZE);
    assign sts.need_room  = (budget_reg < $signed({1'b0, al_reg}));
    assign sts.scan_more  = (cur_reg != NIL) && (guard_reg < LW'(NODES));
    assign sts.pick_nil   = (pick_reg == NIL);
    assign sts.clear_last = (clr_reg == IW'(NODES - 1));

    assign status        = ostat_reg;
    assign result_handle = orh_reg;
    assign free_budget   = obud_reg;
    assign evicted_count = oev_reg;
    assign done          = done_reg;

endmodule

FILE: rtl/core/handle_heap_lru_discard.sv
// Top level of the handle heap manager with least-recently-used discard.
// Depends on hhlru_pkg, hhlru_ctrl and hhlru_dpath.

// A command is taken when start is high and busy is low; its result appears on
// status, result_handle, free_budget and evicted_count with done high for exactly
// one cycle, and cannot be held off. After reset the block sweeps its entry memory
// with busy high; pool_size writes are taken at any time. A resize that needs room
// runs eviction passes, each walking the age list through the single-port entry
// memory and dropping the oldest unlocked resident entry; if a pass finds none,
// the resize ends with no room.
module handle_heap_lru_discard #(
    parameter int NODES       = 256,
    parameter int FIXED_SLOTS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [7:0]         handle,
    input  logic [23:0]        size,
    input  logic [31:0]        now,
    input  logic               pool_size_we,
    input  logic [23:0]        pool_size_wdata,
    output logic               done,
    output logic [2:0]         status,
    output logic [7:0]         result_handle,
    output logic signed [25:0] free_budget,
    output logic [8:0]         evicted_count
);

    hhlru_pkg::ctl_t ctl;
    hhlru_pkg::sts_t sts;

    // Sequence the commands
    hhlru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Hold the tables and compute results
    hhlru_dpath #(
        .NODES       (NODES),
        .FIXED_SLOTS (FIXED_SLOTS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cmd             (cmd),
        .handle          (handle),
        .size            (size),
        .now             (now),
        .pool_size_we    (pool_size_we),
        .pool_size_wdata (pool_size_wdata),
        .status          (status),
        .result_handle   (result_handle),
        .free_budget     (free_budget),
        .evicted_count   (evicted_count),
        .done            (done)
    );

`ifndef NO_ASSERTIONS
    // An accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A result is shown for one cycle only
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A result completes the command, so the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result delivered while still busy");
`endif

endmodule
